@@ hdl/lcbb_pkg.sv @@
// ----------------------------------------------------------------------------
// lcbb_pkg: shared types and constants of the lru cache byte budget unit
// Request codes, field widths, register indexes, the controller state type and
// the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package lcbb_pkg;

  // field widths
  localparam int MODE_W      = 2;
  localparam int DATA_W      = 32;
  localparam int STAMP_W     = 64;
  localparam int MASK_W      = 8;
  localparam int SLOT_W      = 3;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 80;
  localparam int OUT_PAD_W   = 3;
  localparam int CFG_ADDR_W  = 1;

  // request codes
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STORE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_ENTRY = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_TOTAL = 1'b1;

  // register reset values
  localparam logic [DATA_W-1:0] MAX_ENTRY_RST = 32'd4194304;
  localparam logic [DATA_W-1:0] MAX_TOTAL_RST = 32'd33554432;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_TOUCH,
    ST_PLACE,
    ST_EVCHK,
    ST_EVSCAN,
    ST_EVDROP,
    ST_COMMIT,
    ST_CLEAR,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic scan_go;
    logic scan_excl;
    logic touch;
    logic place;
    logic evdrop;
    logic commit;
    logic clear;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              key_nz;
    logic              store_ok;
    logic              scan_done;
    logic              place_ok;
    logic              need_evict;
    logic              victim_ok;
    logic              out_free;
  } status_t;

endpackage

@@ hdl/lcbb_ctrl.sv @@
// ----------------------------------------------------------------------------
// lcbb_ctrl: request sequencer
// Steps one request at a time through decode, slot scans, placement, the
// eviction loop, commit or clear, and result hand-off.
// ----------------------------------------------------------------------------
module lcbb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  lcbb_pkg::status_t sts_i,
  output lcbb_pkg::cmd_t    cmd_o
);
  import lcbb_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (sts_i.mode)
          MODE_LOOKUP: state_nxt = sts_i.key_nz ? ST_SCAN : ST_OUT;
          MODE_STORE:  state_nxt = sts_i.store_ok ? ST_SCAN : ST_OUT;
          MODE_CLEAR:  state_nxt = ST_CLEAR;
          default:     state_nxt = ST_OUT;
        endcase
      end
      ST_SCAN: begin
        if (sts_i.scan_done) begin
          state_nxt = (sts_i.mode == MODE_STORE) ? ST_PLACE : ST_TOUCH;
        end
      end
      ST_TOUCH:  state_nxt = ST_OUT;
      ST_PLACE:  state_nxt = sts_i.place_ok ? ST_EVCHK : ST_OUT;
      ST_EVCHK:  state_nxt = sts_i.need_evict ? ST_EVSCAN : ST_COMMIT;
      ST_EVSCAN: begin
        if (sts_i.scan_done) state_nxt = ST_EVDROP;
      end
      ST_EVDROP: state_nxt = sts_i.victim_ok ? ST_EVCHK : ST_OUT;
      ST_COMMIT: state_nxt = ST_OUT;
      ST_CLEAR:  state_nxt = ST_OUT;
      ST_OUT: begin
        if (sts_i.out_free) state_nxt = ST_IDLE;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o     = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd_o.latch = in_tvalid;
      end
      ST_SCAN:   cmd_o.scan_go = 1'b1;
      ST_EVSCAN: begin
        cmd_o.scan_go   = 1'b1;
        cmd_o.scan_excl = 1'b1;
      end
      ST_TOUCH:  cmd_o.touch    = 1'b1;
      ST_PLACE:  cmd_o.place    = 1'b1;
      ST_EVDROP: cmd_o.evdrop   = 1'b1;
      ST_COMMIT: cmd_o.commit   = 1'b1;
      ST_CLEAR:  cmd_o.clear    = 1'b1;
      ST_OUT:    cmd_o.load_out = sts_i.out_free;
      default:   cmd_o = '0;
    endcase
  end

endmodule

@@ hdl/lcbb_dpath.sv @@
// ----------------------------------------------------------------------------
// lcbb_dpath: slot directory datapath
// Holds the slot memories, used bits, byte total and use counter, runs the
// pipelined slot scan and builds the result word.
// ----------------------------------------------------------------------------
module lcbb_dpath #(
  parameter int SLOTS    = 8,
  parameter int KEY_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [lcbb_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic [lcbb_pkg::MODE_W-1:0]       in_tuser,
  input  logic                              cfg_we,
  input  logic [lcbb_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [lcbb_pkg::DATA_W-1:0]       cfg_wdata,
  input  logic                              out_tready,
  output logic                              out_tvalid,
  output logic [lcbb_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  lcbb_pkg::cmd_t                    cmd_i,
  output lcbb_pkg::status_t                 sts_o
);
  import lcbb_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int KW = (KEY_BITS < DATA_W) ? KEY_BITS : DATA_W;
  localparam int MB = (SLOTS < MASK_W) ? SLOTS : MASK_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  // request and configuration
  logic [MODE_W-1:0]  mode_r;
  logic [KW-1:0]      key_r;
  logic [DATA_W-1:0]  size_r;
  logic [DATA_W-1:0]  max_entry_r, max_total_r;

  // slot memories and directory state
  logic [KW-1:0]      key_mem   [SLOTS];
  logic [DATA_W-1:0]  size_mem  [SLOTS];
  logic [STAMP_W-1:0] stamp_mem [SLOTS];
  logic [KW-1:0]      rd_key_r;
  logic [DATA_W-1:0]  rd_size_r;
  logic [STAMP_W-1:0] rd_stamp_r;
  logic [SLOTS-1:0]   used_r, used_nxt;
  logic [DATA_W-1:0]  total_r, total_nxt;
  logic [STAMP_W-1:0] cnt_r, cnt_nxt;

  // scan pipeline
  logic [IW-1:0]      rd_idx_r, pidx_r;
  logic               issue_done_r, pv_r;
  logic               m_found_r, f_found_r, o_found_r;
  logic [IW-1:0]      m_idx_r, f_idx_r, o_idx_r;
  logic [DATA_W-1:0]  m_size_r, o_size_r;
  logic [STAMP_W-1:0] o_stamp_r;
  logic               first, cur_used, skip, m_prev, f_prev, o_prev;
  logic               take_m, take_f, take_o;

  // result fields
  logic [IW-1:0]      target_r, target_nxt;
  logic               hit_r, hit_nxt, stored_r, stored_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic [DATA_W-1:0]  size_out_r, size_out_nxt;
  logic [MASK_W-1:0]  mask_r, mask_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r;

  // slot drop
  logic               drop_en;
  logic [IW-1:0]      drop_idx;
  logic [DATA_W-1:0]  drop_size;

  // memory write port
  logic               stamp_we, entry_we;
  logic [IW-1:0]      wr_idx;
  logic [STAMP_W-1:0] cnt_inc;

  assign cnt_inc  = cnt_r + STAMP_W'(1);
  assign stamp_we = (cmd_i.touch && m_found_r) || cmd_i.commit;
  assign entry_we = cmd_i.commit;
  assign wr_idx   = cmd_i.touch ? m_idx_r : target_r;

  // request latch and configuration registers
  always_ff @(posedge clk) begin
    if (cmd_i.latch) begin
      mode_r <= in_tuser;
      key_r  <= in_tdata[KW-1:0];
      size_r <= in_tdata[IN_TDATA_W-1:DATA_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_entry_r <= MAX_ENTRY_RST;
      max_total_r <= MAX_TOTAL_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_MAX_ENTRY: max_entry_r <= cfg_wdata;
        CFG_MAX_TOTAL: max_total_r <= cfg_wdata;
      endcase
    end
  end

  // slot memories, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (stamp_we) stamp_mem[wr_idx] <= cnt_inc;
    if (entry_we) begin
      key_mem[wr_idx]  <= key_r;
      size_mem[wr_idx] <= size_r;
    end
    rd_key_r   <= key_mem[rd_idx_r];
    rd_size_r  <= size_mem[rd_idx_r];
    rd_stamp_r <= stamp_mem[rd_idx_r];
  end

  // scan compare on the slot read last cycle
  always_comb begin
    first    = (pidx_r == '0);
    cur_used = used_r[pidx_r];
    skip     = cmd_i.scan_excl && (pidx_r == target_r);
    m_prev   = !first && m_found_r;
    f_prev   = !first && f_found_r;
    o_prev   = !first && o_found_r;
    take_m   = cur_used && (rd_key_r == key_r) && !m_prev;
    take_f   = !cur_used && !f_prev;
    take_o   = cur_used && !skip && (!o_prev || (rd_stamp_r < o_stamp_r));
  end

  // scan control and found flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r     <= '0;
      pidx_r       <= '0;
      issue_done_r <= 1'b0;
      pv_r         <= 1'b0;
      m_found_r    <= 1'b0;
      f_found_r    <= 1'b0;
      o_found_r    <= 1'b0;
    end else begin
      pv_r <= cmd_i.scan_go && !issue_done_r;
      if (cmd_i.scan_go && !issue_done_r) begin
        pidx_r <= rd_idx_r;
        if (rd_idx_r == LAST_IDX) begin
          issue_done_r <= 1'b1;
        end else begin
          rd_idx_r <= rd_idx_r + IW'(1);
        end
      end
      if (sts_o.scan_done) begin
        rd_idx_r     <= '0;
        issue_done_r <= 1'b0;
      end
      if (pv_r) begin
        m_found_r <= m_prev || take_m;
        f_found_r <= f_prev || take_f;
        o_found_r <= o_prev || take_o;
      end
    end
  end

  // scan winners
  always_ff @(posedge clk) begin
    if (pv_r) begin
      if (take_m) begin
        m_idx_r  <= pidx_r;
        m_size_r <= rd_size_r;
      end
      if (take_f) f_idx_r <= pidx_r;
      if (take_o) begin
        o_idx_r   <= pidx_r;
        o_size_r  <= rd_size_r;
        o_stamp_r <= rd_stamp_r;
      end
    end
  end

  // directory and result updates
  always_comb begin
    used_nxt     = used_r;
    total_nxt    = total_r;
    cnt_nxt      = cnt_r;
    mask_nxt     = mask_r;
    hit_nxt      = hit_r;
    stored_nxt   = stored_r;
    slot_nxt     = slot_r;
    size_out_nxt = size_out_r;
    target_nxt   = target_r;
    drop_en      = 1'b0;
    drop_idx     = o_idx_r;
    drop_size    = o_size_r;
    priority if (cmd_i.latch) begin
      mask_nxt     = '0;
      hit_nxt      = 1'b0;
      stored_nxt   = 1'b0;
      slot_nxt     = '0;
      size_out_nxt = '0;
    end else if (cmd_i.touch && m_found_r) begin
      cnt_nxt      = cnt_inc;
      hit_nxt      = 1'b1;
      slot_nxt     = SLOT_W'(m_idx_r);
      size_out_nxt = m_size_r;
    end else if (cmd_i.place) begin
      // matching slot first, then first free slot, then oldest slot
      priority if (m_found_r) begin
        target_nxt = m_idx_r;
        drop_en    = 1'b1;
        drop_idx   = m_idx_r;
        drop_size  = m_size_r;
      end else if (f_found_r) begin
        target_nxt = f_idx_r;
      end else if (o_found_r) begin
        target_nxt = o_idx_r;
        drop_en    = 1'b1;
      end
    end else if (cmd_i.evdrop && o_found_r) begin
      drop_en = 1'b1;
    end else if (cmd_i.commit) begin
      used_nxt[target_r] = 1'b1;
      cnt_nxt            = cnt_inc;
      total_nxt          = total_r + size_r;
      stored_nxt         = 1'b1;
      slot_nxt           = SLOT_W'(target_r);
    end else if (cmd_i.clear) begin
      for (int j = 0; j < MB; j++) mask_nxt[j] = used_r[j];
      used_nxt  = '0;
      total_nxt = '0;
      cnt_nxt   = '0;
    end
    // free one slot, byte total floors at zero
    if (drop_en) begin
      used_nxt[drop_idx] = 1'b0;
      total_nxt = (drop_size <= total_r) ? (total_r - drop_size) : '0;
      for (int j = 0; j < MB; j++) begin
        if (drop_idx == IW'(j)) mask_nxt[j] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= '0;
      total_r <= '0;
      cnt_r   <= '0;
    end else begin
      used_r  <= used_nxt;
      total_r <= total_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mask_r     <= mask_nxt;
    hit_r      <= hit_nxt;
    stored_r   <= stored_nxt;
    slot_r     <= slot_nxt;
    size_out_r <= size_out_nxt;
    target_r   <= target_nxt;
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd_i.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load_out) begin
      out_data_r <= {{OUT_PAD_W{1'b0}}, total_r, mask_r, size_out_r, slot_r, stored_r,
                     hit_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // status to controller
  always_comb begin
    sts_o.mode       = mode_r;
    sts_o.key_nz     = (key_r != '0);
    sts_o.store_ok   = (key_r != '0) && (size_r != '0) && (size_r <= max_entry_r) &&
                       (size_r <= max_total_r);
    sts_o.scan_done  = pv_r && (pidx_r == LAST_IDX);
    sts_o.place_ok   = m_found_r || f_found_r || o_found_r;
    sts_o.need_evict = (total_r > (max_total_r - size_r));
    sts_o.victim_ok  = o_found_r;
    sts_o.out_free   = !out_valid_r || out_tready;
  end

  // the slot taking the new entry is free when it is written
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.commit |-> !used_r[target_r])
    else $error("commit into a used slot");

  // eviction never hits the slot reserved for the new entry
  a_victim_not_target: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_i.evdrop && o_found_r) |-> (o_idx_r != target_r))
    else $error("eviction of the target slot");

  // a finished result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.load_out |-> (!out_valid_r || out_tready))
    else $error("result overwritten");

  // compare stage only runs behind an issued scan read
  a_scan_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    pv_r |-> $past(cmd_i.scan_go))
    else $error("scan compare without a read");

endmodule

@@ hdl/lru_cache_byte_budget_unit.sv @@
// ----------------------------------------------------------------------------
// lru_cache_byte_budget_unit: lru cache directory with a byte budget
// Slot directory that answers lookups, stores with least-recently-used
// eviction under a total byte budget, and clears.
// ----------------------------------------------------------------------------
//  channel  direction  contents
//  in_      slave      word: tdata = key, size; tuser = mode
//  out_     master     word: tdata = hit, stored, slot, size_out, mask, bytes
//  cfg_     write      index 0 max_entry_bytes, index 1 max_total_bytes
//
// one request at a time; a slot scan reads one slot per cycle from the slot
// memories. reset is synchronous: all slots free, byte total and use counter
// zero, limits at their defaults. a new word is taken while the previous result
// waits; a stalled result holds the sequencer at hand-off.
// ----------------------------------------------------------------------------
module lru_cache_byte_budget_unit #(
  parameter int SLOTS    = 8,
  parameter int KEY_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // key [31:0], size [63:32]
  input  logic [lcbb_pkg::IN_TDATA_W-1:0]   in_tdata,
  // mode [1:0]
  input  logic [lcbb_pkg::MODE_W-1:0]       in_tuser,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // hit [0], stored [1], slot [4:2], size_out [36:5], evicted_mask [44:37],
  // resident_bytes [76:45], zero [79:77]
  output logic [lcbb_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_we,
  input  logic [lcbb_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [lcbb_pkg::DATA_W-1:0]       cfg_wdata
);
  import lcbb_pkg::*;

  cmd_t    cmd;
  status_t sts;

  lcbb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  lcbb_dpath #(
    .SLOTS    (SLOTS),
    .KEY_BITS (KEY_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule

@@ tb/sv/lcbb_dir_checker.sv @@
// ----------------------------------------------------------------------------
// lcbb_dir_checker: reply checker for the lru cache byte budget unit
// Keeps its own copy of the slot directory and limits, works out the reply
// for every accepted request word and compares each reply word, field by
// field, with the oldest reply still owed.
// ----------------------------------------------------------------------------
module lcbb_dir_checker #(
  parameter int SLOTS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // key [31:0], size [63:32]
  input  logic [lcbb_pkg::IN_TDATA_W-1:0]  in_tdata,
  // mode [1:0]
  input  logic [lcbb_pkg::MODE_W-1:0]      in_tuser,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  // hit [0], stored [1], slot [4:2], size_out [36:5], evicted_mask [44:37],
  // resident_bytes [76:45], zero [79:77]
  input  logic [lcbb_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_we,
  input  logic [lcbb_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [lcbb_pkg::DATA_W-1:0]      cfg_wdata,
  output int                               fail_count,
  output int                               pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import lcbb_pkg::*;

  // reply word, first member in the top bits
  typedef struct packed {
    logic [DATA_W-1:0] resident;
    logic [MASK_W-1:0] evicted;
    logic [DATA_W-1:0] size_out;
    logic [SLOT_W-1:0] slot;
    logic              stored;
    logic              hit;
  } reply_t;

  // directory copy
  logic [DATA_W-1:0]  dir_key   [SLOTS];
  logic [DATA_W-1:0]  dir_size  [SLOTS];
  logic [STAMP_W-1:0] dir_stamp [SLOTS];
  logic               dir_used  [SLOTS];
  logic [DATA_W-1:0]  resident_bytes;
  logic [STAMP_W-1:0] use_count;
  logic [DATA_W-1:0]  lim_entry;
  logic [DATA_W-1:0]  lim_total;

  reply_t owed_replies[$];
  reply_t want;
  reply_t got;
  int     n_bad  = 0;
  int     n_owed = 0;

  assign fail_count = n_bad;
  assign pending    = n_owed;

  function automatic void reset_directory();
    for (int i = 0; i < SLOTS; i++) begin
      dir_key[i]   = '0;
      dir_size[i]  = '0;
      dir_stamp[i] = '0;
      dir_used[i]  = 1'b0;
    end
    resident_bytes = '0;
    use_count      = '0;
  endfunction

  // empty one slot; the byte total never goes below zero
  function automatic void drop_entry(input int i, inout logic [MASK_W-1:0] m);
    if (dir_used[i]) begin
      resident_bytes = (dir_size[i] <= resident_bytes) ?
                       resident_bytes - dir_size[i] : '0;
      dir_key[i]   = '0;
      dir_size[i]  = '0;
      dir_stamp[i] = '0;
      dir_used[i]  = 1'b0;
      if (i < MASK_W) m[i] = 1'b1;
    end
  endfunction

  // least recently used slot other than skip, lowest index on equal stamps
  function automatic bit find_lru(input int skip, output int idx);
    bit                 have;
    logic [STAMP_W-1:0] best;
    have = 1'b0;
    best = '0;
    idx  = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (i != skip && dir_used[i] && (!have || dir_stamp[i] < best)) begin
        have = 1'b1;
        best = dir_stamp[i];
        idx  = i;
      end
    end
    return have;
  endfunction

  // apply one request to the directory and return its reply
  function automatic reply_t apply_request(input logic [MODE_W-1:0] mode,
                                           input logic [DATA_W-1:0] key,
                                           input logic [DATA_W-1:0] size);
    reply_t            r;
    logic [MASK_W-1:0] m;
    int                tgt;
    int                vic;
    bit                ok;
    bit                matched;
    r       = '0;
    m       = '0;
    matched = 1'b0;
    ok      = 1'b1;
    tgt     = SLOTS;
    vic     = 0;
    case (mode)
      MODE_LOOKUP: begin
        if (key != '0) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (!matched && dir_used[i] && dir_key[i] == key) begin
              matched      = 1'b1;
              use_count    = use_count + 1'b1;
              dir_stamp[i] = use_count;
              r.hit        = 1'b1;
              r.slot       = SLOT_W'(i);
              r.size_out   = dir_size[i];
            end
          end
        end
      end
      MODE_STORE: begin
        if (key != '0 && size != '0 && size <= lim_entry && size <= lim_total) begin
          // same key first, else first free slot
          for (int i = 0; i < SLOTS; i++) begin
            if (!matched) begin
              if (dir_used[i] && dir_key[i] == key) begin
                tgt     = i;
                matched = 1'b1;
                drop_entry(i, m);
              end else if (tgt == SLOTS && !dir_used[i]) begin
                tgt = i;
              end
            end
          end
          // directory full: replace the oldest
          if (tgt == SLOTS) begin
            if (find_lru(SLOTS, vic)) begin
              tgt = vic;
              drop_entry(vic, m);
            end else begin
              ok = 1'b0;
            end
          end
          // make room under the budget
          while (ok && resident_bytes > lim_total - size) begin
            if (!find_lru(tgt, vic)) ok = 1'b0;
            else drop_entry(vic, m);
          end
          if (ok) begin
            use_count      = use_count + 1'b1;
            dir_key[tgt]   = key;
            dir_size[tgt]  = size;
            dir_stamp[tgt] = use_count;
            dir_used[tgt]  = 1'b1;
            resident_bytes = resident_bytes + size;
            r.stored       = 1'b1;
            r.slot         = SLOT_W'(tgt);
          end
        end
      end
      MODE_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (dir_used[i] && i < MASK_W) m[i] = 1'b1;
        end
        reset_directory();
      end
      default: begin
      end
    endcase
    r.evicted  = m;
    r.resident = resident_bytes;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [DATA_W-1:0] exp_v,
                                      input logic [DATA_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      n_bad++;
    end
  endfunction

  // watch config writes, reply words and request words
  always @(posedge clk) begin
    if (!rst_n) begin
      reset_directory();
      lim_entry = MAX_ENTRY_RST;
      lim_total = MAX_TOTAL_RST;
      owed_replies.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_MAX_ENTRY: lim_entry = cfg_wdata;
          CFG_MAX_TOTAL: lim_total = cfg_wdata;
          default: begin
          end
        endcase
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[$bits(reply_t)-1:0];
        if (owed_replies.size() == 0) begin
          $error("reply word with no request outstanding");
          n_bad++;
        end else begin
          want = owed_replies.pop_front();
          check_field("hit", DATA_W'(want.hit), DATA_W'(got.hit));
          check_field("stored", DATA_W'(want.stored), DATA_W'(got.stored));
          check_field("slot", DATA_W'(want.slot), DATA_W'(got.slot));
          check_field("size_out", want.size_out, got.size_out);
          check_field("evicted_mask", DATA_W'(want.evicted), DATA_W'(got.evicted));
          check_field("resident_bytes", want.resident, got.resident);
        end
      end
      if (in_tvalid && in_tready)
        owed_replies.push_back(apply_request(in_tuser, in_tdata[DATA_W-1:0],
                                             in_tdata[2*DATA_W-1:DATA_W]));
    end
    n_owed = owed_replies.size();
  end

endmodule

@@ tb/sv/lru_cache_byte_budget_unit_tb.sv @@
// ----------------------------------------------------------------------------
// lru_cache_byte_budget_unit_tb: testbench of the lru cache byte budget unit
// Drives directed and random lookups, stores and clears under several limit
// settings with random gaps and stalls on both channels, and long stalls of
// the reply channel; a checker beside the block predicts every reply.
// ----------------------------------------------------------------------------
module lru_cache_byte_budget_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lcbb_pkg::*;

  localparam logic [MODE_W-1:0] MODE_RSVD = 2'd3;
  localparam int KEY_POOL     = 12;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 150;

  logic                   clk;
  logic                   rst_n;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [MODE_W-1:0]      in_tuser;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic                   cfg_we;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [DATA_W-1:0]      cfg_wdata;
  int                     fail_count;
  int                     pending;

  // stimulus settings shared with the ready process
  int unsigned       tx_idle;
  int unsigned       rx_idle;
  int                hold_reqs;
  int                holds_done;
  int                quiet;
  logic [DATA_W-1:0] cur_entry;
  logic [DATA_W-1:0] cur_total;
  logic [DATA_W-1:0] key_pool [KEY_POOL];

  lru_cache_byte_budget_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  lcbb_dir_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // reply channel ready, with random stalls and requested long hold-offs
  initial begin
    out_tready = 1'b0;
    holds_done = 0;
    forever begin
      @(negedge clk);
      if (hold_reqs != holds_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_done++;
      end
      out_tready <= ($urandom_range(99) >= rx_idle);
    end
  end

  // cycles with no word moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("[lru_cache_byte_budget_unit] ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // one request word, after a random gap; returns at the falling edge after accept
  task automatic push_req(input logic [MODE_W-1:0] m, input logic [DATA_W-1:0] k,
                          input logic [DATA_W-1:0] s);
    while ($urandom_range(99) < tx_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {s, k};
    in_tuser  <= m;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // write both limits once the block has handed back every reply
  task automatic set_limits(input logic [DATA_W-1:0] entry_lim,
                            input logic [DATA_W-1:0] total_lim);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_MAX_ENTRY;
    cfg_wdata <= entry_lim;
    @(negedge clk);
    cfg_addr  <= CFG_MAX_TOTAL;
    cfg_wdata <= total_lim;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_entry = entry_lim;
    cur_total = total_lim;
  endtask

  // mostly keys from a small pool so that lookups hit and stores reuse slots
  function automatic logic [DATA_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 3) return '0;
    if (r < 13) return $urandom;
    return key_pool[$urandom_range(KEY_POOL - 1)];
  endfunction

  // sizes around the limits, full range now and then, mostly small
  function automatic logic [DATA_W-1:0] pick_size();
    int unsigned       r;
    logic [DATA_W-1:0] lim;
    logic [DATA_W-1:0] cap;
    r   = $urandom_range(99);
    lim = (cur_entry < cur_total) ? cur_entry : cur_total;
    cap = (lim > 32'd1000) ? 32'd1000 : lim;
    if (r < 3) return '0;
    if (r < 7) return 32'd1;
    if (r < 11) return cur_entry;
    if (r < 14) return cur_entry + 32'd1;
    if (r < 17) return cur_total;
    if (r < 20) return cur_total + 32'd1;
    if (r < 26) return $urandom;
    if (cap < 32'd2) return 32'd1;
    return $urandom_range(cap, 1);
  endfunction

  task automatic run_random(input int n_items, input int hold_at);
    logic [MODE_W-1:0] m;
    int unsigned       r;
    for (int n = 0; n < n_items; n++) begin
      if (n == hold_at) hold_reqs++;
      r = $urandom_range(99);
      if (r < 40) m = MODE_LOOKUP;
      else if (r < 92) m = MODE_STORE;
      else if (r < 96) m = MODE_CLEAR;
      else m = MODE_RSVD;
      push_req(m, pick_key(), pick_size());
    end
  endtask

  initial begin
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = MODE_LOOKUP;
    cfg_we    = 1'b0;
    cfg_addr  = CFG_MAX_ENTRY;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    tx_idle   = 31;
    rx_idle   = 80;
    hold_reqs = 0;
    quiet     = 0;
    cur_entry = MAX_ENTRY_RST;
    cur_total = MAX_TOTAL_RST;
    key_pool[0] = '1;
    key_pool[1] = 32'd1;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = $urandom | 32'h1;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part under small limits
    set_limits(32'd100, 32'd250);
    push_req(MODE_LOOKUP, 32'd5, 32'd0);        // miss on an empty directory
    push_req(MODE_STORE, 32'd0, 32'd10);        // empty key is rejected
    push_req(MODE_STORE, 32'd5, 32'd0);         // zero size is rejected
    push_req(MODE_STORE, 32'd5, 32'd101);       // just above the entry limit
    push_req(MODE_STORE, 32'd5, '1);
    push_req(MODE_STORE, 32'd5, 32'd100);
    push_req(MODE_STORE, 32'd6, 32'd100);
    push_req(MODE_LOOKUP, 32'd5, '1);           // hit, size field ignored
    push_req(MODE_STORE, 32'd7, 32'd80);        // budget forces out key 6
    push_req(MODE_STORE, 32'd5, 32'd50);        // store again over a resident key
    push_req(MODE_LOOKUP, 32'd0, 32'd0);        // empty key never hits
    push_req(MODE_RSVD, 32'd5, 32'd20);         // unused mode does nothing
    push_req(MODE_STORE, '1, 32'd1);
    push_req(MODE_LOOKUP, '1, 32'd0);
    // fill every slot, then replace the least recently used
    for (int k = 10; k < 16; k++) push_req(MODE_STORE, k, 32'd1);
    push_req(MODE_STORE, 32'd20, 32'd100);
    push_req(MODE_STORE, 32'd21, 32'd250);      // whole budget, all others go
    push_req(MODE_CLEAR, 32'd21, 32'd0);
    push_req(MODE_CLEAR, 32'd0, 32'd0);         // clear of an empty directory
    push_req(MODE_STORE, 32'h8000_0000, 32'd1);

    // random part: sender sparse, receiver mostly stalled
    set_limits(32'd64, 32'd256);
    run_random(480, 200);

    // receiver sparse, sender mostly idle
    tx_idle = 80;
    rx_idle = 31;
    set_limits('1, '1);
    run_random(380, -1);
    set_limits('0, '0);
    run_random(40, -1);

    // no idling on either side
    tx_idle = 0;
    rx_idle = 0;
    set_limits(32'd300, 32'd200);
    run_random(400, 150);
    set_limits(32'd1000, 32'd3000);
    run_random(400, -1);
    set_limits(MAX_ENTRY_RST, MAX_TOTAL_RST);
    run_random(130, -1);

    // drain and look for stray replies
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("[lru_cache_byte_budget_unit] OK");
    end else begin
      $display("[lru_cache_byte_budget_unit] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/lcbb_pkg.sv
hdl/lcbb_ctrl.sv
hdl/lcbb_dpath.sv
hdl/lru_cache_byte_budget_unit.sv
tb/sv/lcbb_dir_checker.sv
tb/sv/lru_cache_byte_budget_unit_tb.sv
